/* rtl/horner_polynomial_evaluator_unit_assert.svh */
// Assertion macros used by the checker file of this block.
`ifndef HORNER_POLYNOMIAL_EVALUATOR_UNIT_ASSERT_SVH
`define HORNER_POLYNOMIAL_EVALUATOR_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define HPE_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hpe assertion failed: same-cycle implication");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define HPE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hpe assertion failed: next-cycle implication");

`endif

/* rtl/hpe_pkg.sv */
package hpe_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int COEF_COUNT = 8;
  localparam int NUM_REGS   = 8;
  localparam int REG_IDX_W  = $clog2(NUM_REGS);
  localparam int ADDR_W     = REG_IDX_W + 2;
  localparam int APB_DATA_W = 32;

  typedef logic signed [DATA_WIDTH-1:0] hpe_data_t;

  typedef struct packed {
    hpe_data_t x;
    hpe_data_t acc;
    logic      ovf;
  } hpe_word_t;

endpackage

/* rtl/horner_polynomial_evaluator_unit.sv */
// An accepted word passes through two register stages per Horner step
// (a multiply stage, then a round, add and saturate stage) over eight steps.
// Throughput: one word per cycle; each stage holds under stall and fills bubbles on its own.
// Reset clears all coefficient registers to zero and empties the pipeline.
module horner_polynomial_evaluator_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [hpe_pkg::ADDR_W-1:0]      paddr,
  input  logic [hpe_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [hpe_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic signed [hpe_pkg::DATA_WIDTH-1:0] point_x_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [hpe_pkg::DATA_WIDTH-1:0] poly_value_o,
  output logic                            overflow_o
);
  import hpe_pkg::*;

  hpe_data_t              coef_q [NUM_REGS];
  logic [REG_IDX_W-1:0]   reg_idx;
  logic                   cfg_wr;

  logic      valid_s [COEF_COUNT+1];
  logic      ready_s [COEF_COUNT+1];
  hpe_word_t word_s  [COEF_COUNT+1];

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign prdata  = APB_DATA_W'(coef_q[reg_idx]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        coef_q[i] <= '0;
      end
    end else if (cfg_wr) begin
      coef_q[reg_idx] <= pwdata[DATA_WIDTH-1:0];
    end
  end

  assign valid_s[0]      = in_valid_i;
  assign word_s[0].x     = point_x_i;
  assign word_s[0].acc   = '0;
  assign word_s[0].ovf   = 1'b0;
  assign in_stall_o      = !ready_s[0];

  for (genvar k = 0; k < COEF_COUNT; k++) begin : g_step
    hpe_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .coef_i  (coef_q[COEF_COUNT-1-k]),
      .valid_i (valid_s[k]),
      .word_i  (word_s[k]),
      .ready_o (ready_s[k]),
      .valid_o (valid_s[k+1]),
      .word_o  (word_s[k+1]),
      .ready_i (ready_s[k+1])
    );
  end

  assign ready_s[COEF_COUNT] = !out_stall_i;
  assign out_valid_o         = valid_s[COEF_COUNT];
  assign poly_value_o        = word_s[COEF_COUNT].acc;
  assign overflow_o          = word_s[COEF_COUNT].ovf;

endmodule

/* rtl/hpe_step.sv */
module hpe_step (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hpe_pkg::hpe_data_t coef_i,
  input  logic              valid_i,
  input  hpe_pkg::hpe_word_t word_i,
  output logic              ready_o,
  output logic              valid_o,
  output hpe_pkg::hpe_word_t word_o,
  input  logic              ready_i
);
  import hpe_pkg::*;

  localparam int PROD_W = 2 * DATA_WIDTH;
  localparam int SUM_W  = PROD_W + 1;
  localparam int TOT_W  = PROD_W + 2;
  localparam logic signed [SUM_W-1:0] HALF = (SUM_W'(1) << FRAC_BITS) >> 1;
  localparam logic signed [TOT_W-1:0] MAX_V =
    {{(TOT_W-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [TOT_W-1:0] MIN_V = ~MAX_V;

  logic                    v1_q, v2_q;
  logic                    ld1, ld2;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  hpe_data_t               x1_q;
  logic                    ovf1_q;
  hpe_word_t               w2_q, w2_d;

  logic signed [SUM_W-1:0] rnd_sum;
  logic signed [SUM_W-1:0] rnd;
  logic signed [TOT_W-1:0] tot;

  assign ld2     = !v2_q || ready_i;
  assign ld1     = !v1_q || ld2;
  assign ready_o = ld1;
  assign valid_o = v2_q;
  assign word_o  = w2_q;

  assign prod_d = PROD_W'(word_i.x) * PROD_W'(word_i.acc);

  always_comb begin
    rnd_sum = $signed({prod_q[PROD_W-1], prod_q}) + HALF;
    rnd     = rnd_sum >>> FRAC_BITS;
    tot     = $signed({rnd[SUM_W-1], rnd}) + TOT_W'(coef_i);
    w2_d.x  = x1_q;
    w2_d.ovf = ovf1_q;
    if (tot > MAX_V) begin
      w2_d.acc = MAX_V[DATA_WIDTH-1:0];
      w2_d.ovf = 1'b1;
    end else if (tot < MIN_V) begin
      w2_d.acc = MIN_V[DATA_WIDTH-1:0];
      w2_d.ovf = 1'b1;
    end else begin
      w2_d.acc = tot[DATA_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (ld1) begin
        v1_q <= valid_i;
      end
      if (ld2) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld1 && valid_i) begin
      prod_q <= prod_d;
      x1_q   <= word_i.x;
      ovf1_q <= word_i.ovf;
    end
    if (ld2 && v1_q) begin
      w2_q <= w2_d;
    end
  end

endmodule

/* rtl/hpe_chk.sv */
`include "horner_polynomial_evaluator_unit_assert.svh"

module hpe_chk (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            pready,
  input logic                            in_stall_o,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic signed [hpe_pkg::DATA_WIDTH-1:0] poly_value_o,
  input logic                            overflow_o
);
  import hpe_pkg::*;

  `HPE_ASSERT_NEXT(a_out_valid_hold, out_valid_o && out_stall_i, out_valid_o)
  `HPE_ASSERT_NEXT(a_out_value_hold, out_valid_o && out_stall_i, $stable(poly_value_o))
  `HPE_ASSERT_NEXT(a_out_ovf_hold, out_valid_o && out_stall_i, $stable(overflow_o))
  `HPE_ASSERT_IMPL(a_empty_tail_accepts, !out_valid_o, !in_stall_o)
  `HPE_ASSERT_IMPL(a_apb_no_wait, 1'b1, pready)

endmodule

bind horner_polynomial_evaluator_unit hpe_chk u_hpe_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .pready       (pready),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .poly_value_o (poly_value_o),
  .overflow_o   (overflow_o)
);
